// ===== hw/rtl/pmca_pkg.sv =====
// Package for the minimum corner angle unit: widths, CORDIC table, job types.
// Used by every module of the block; depends on nothing.
package pmca_pkg;
    localparam int COORD_BITS   = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int MAX_VERTICES = 65535;
    localparam int EDGE_SHIFT   = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
    localparam int EDGE_BITS    = COORD_BITS + 1 - EDGE_SHIFT;
    localparam int PROD_BITS    = 2 * EDGE_BITS + 1;
    // CORDIC datapath: products plus headroom for the prerotation and gain.
    localparam int CW           = PROD_BITS + 3;
    localparam int STEP_BITS    = $clog2(CORDIC_STEPS + 1);
    localparam int CNT_BITS     = 16;
    localparam int ANG_BITS     = 16;
    localparam logic [ANG_BITS-1:0] FULL_TURN = 16'd46080;
    localparam int QDEPTH       = 4;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // One corner job: three points, plus flags to compute an angle, deliver the result and deliver zero.
    typedef struct packed {
        t_point a;
        t_point b;
        t_point c;
        logic   eval;   // compute an angle for this job
        logic   emit;   // deliver the result after this job
        logic   zero;   // deliver zero (fewer than three vertices)
    } t_job;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001; default: r = 32'h00000000;
        endcase
        return r;
    endfunction
endpackage

// ===== hw/rtl/pmca_if.sv =====
// Valid/ready channel interfaces for vertices in and angles out.
// Depends on pmca_pkg.
interface pmca_vertex_if;
    import pmca_pkg::*;
    logic   valid;
    logic   ready;
    t_coord vertex_x;
    t_coord vertex_y;
    logic   last_vertex;
    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

interface pmca_angle_if;
    logic        valid;
    logic        ready;
    logic [15:0] least_angle;
    modport source (output valid, output least_angle, input ready);
    modport sink (input valid, input least_angle, output ready);
endinterface

// ===== hw/rtl/pmca_front.sv =====
// Front end: keeps first and recent vertices and issues corner jobs.
// Depends on pmca_pkg and pmca_if.
module pmca_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pmca_vertex_if.sink   i_vtx,
    output pmca_pkg::t_job o_job,
    output logic          o_job_valid,
    input  logic          i_job_ready
);
    import pmca_pkg::*;

    typedef enum logic [1:0] {S_TAKE, S_WRAP1, S_WRAP2} t_state;

    t_state            r_state, n_state;
    t_point            r_first0, r_first1, r_rec0, r_rec1;
    logic [CNT_BITS-1:0] r_cnt;
    t_point            p;
    logic [CNT_BITS-1:0] cnt1;

    assign p.x = i_vtx.vertex_x;
    assign p.y = i_vtx.vertex_y;
    assign cnt1 = (r_cnt < CNT_BITS'(MAX_VERTICES)) ? r_cnt + 1'b1 : r_cnt;
    assign i_vtx.ready = (r_state == S_TAKE) && i_job_ready;

    // Job selection per state.
    always_comb begin
        o_job = '0;
        o_job_valid = 1'b0;
        n_state = r_state;
        unique case (r_state)
            S_TAKE: begin
                o_job.a = r_rec0; o_job.b = r_rec1; o_job.c = p;
                o_job.eval = (cnt1 >= CNT_BITS'(3));
                o_job.zero = i_vtx.last_vertex && (cnt1 < CNT_BITS'(3));
                o_job.emit = o_job.zero;
                o_job_valid = i_vtx.valid;
                if (i_vtx.valid && i_job_ready && i_vtx.last_vertex && !o_job.zero)
                    n_state = S_WRAP1;
            end
            S_WRAP1: begin
                o_job.a = r_rec0; o_job.b = r_rec1; o_job.c = r_first0;
                o_job.eval = 1'b1;
                o_job_valid = 1'b1;
                if (i_job_ready) n_state = S_WRAP2;
            end
            default: begin
                o_job.a = r_rec1; o_job.b = r_first0; o_job.c = r_first1;
                o_job.eval = 1'b1; o_job.emit = 1'b1;
                o_job_valid = 1'b1;
                if (i_job_ready) n_state = S_TAKE;
            end
        endcase
    end

    // State and vertex history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_cnt <= '0;
            r_first0 <= '0; r_first1 <= '0; r_rec0 <= '0; r_rec1 <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_TAKE && i_vtx.valid && i_job_ready) begin
                if (cnt1 == CNT_BITS'(1)) r_first0 <= p;
                if (cnt1 == CNT_BITS'(2)) r_first1 <= p;
                r_rec0 <= r_rec1;
                r_rec1 <= p;
                if (i_vtx.last_vertex && o_job.zero) begin
                    r_cnt <= '0;
                    r_first0 <= '0; r_first1 <= '0; r_rec0 <= '0; r_rec1 <= '0;
                end else begin
                    r_cnt <= cnt1;
                end
            end else if (r_state == S_WRAP2 && i_job_ready) begin
                r_cnt <= '0;
                r_first0 <= '0; r_first1 <= '0; r_rec0 <= '0; r_rec1 <= '0;
            end
        end
    end
endmodule

// ===== hw/rtl/pmca_queue.sv =====
// Short job queue between front end and angle engine.
// Depends on pmca_pkg.
module pmca_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pmca_pkg::t_job i_job,
    input  logic           i_valid,
    output logic           o_ready,
    output pmca_pkg::t_job o_job,
    output logic           o_valid,
    input  logic           i_ready
);
    import pmca_pkg::*;
    localparam int AW = $clog2(QDEPTH);

    t_job          r_mem [QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr, rd;

    assign o_ready = (r_cnt != (AW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    // Storage, written at the tail.
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_job;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

// ===== hw/rtl/pmca_engine.sv =====
// Angle engine: edge products, iterative CORDIC, scaling, running minimum.
// Depends on pmca_pkg and pmca_if.
module pmca_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pmca_pkg::t_job i_job,
    input  logic           i_valid,
    output logic           o_ready,
    pmca_angle_if.source   o_res
);
    import pmca_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EDGE, S_PROD, S_ROT, S_SCALE, S_MIN, S_OUT} t_state;

    t_state                     r_state;
    t_job                       r_job;
    logic signed [EDGE_BITS-1:0] r_ux, r_uy, r_wx, r_wy;
    logic signed [PROD_BITS-1:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [CW-1:0]       r_x, r_y;
    logic [31:0]                r_z;
    logic [STEP_BITS-1:0]       r_i;
    logic [47:0]                r_prod;
    logic [ANG_BITS-1:0]        r_min;
    logic                       r_degen;
    logic [15:0]                r_out;
    logic                       r_ovalid;

    logic signed [COORD_BITS:0] dux, duy, dwx, dwy;
    logic signed [CW-1:0]       dot, ncr, xs, ys;
    logic [ANG_BITS-1:0]        ang;
    logic [16:0]                rnd;

    assign dux = {r_job.a.x[COORD_BITS-1], r_job.a.x} - {r_job.b.x[COORD_BITS-1], r_job.b.x};
    assign duy = {r_job.a.y[COORD_BITS-1], r_job.a.y} - {r_job.b.y[COORD_BITS-1], r_job.b.y};
    assign dwx = {r_job.c.x[COORD_BITS-1], r_job.c.x} - {r_job.b.x[COORD_BITS-1], r_job.b.x};
    assign dwy = {r_job.c.y[COORD_BITS-1], r_job.c.y} - {r_job.b.y[COORD_BITS-1], r_job.b.y};
    assign dot = CW'(r_p1) + CW'(r_p2);
    assign ncr = CW'(r_p4) - CW'(r_p3);
    // Arithmetic shifts round toward minus infinity.
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign rnd = 17'(r_prod[47:32]) + 17'(r_prod[31]);
    assign ang = r_degen ? '0 : ((rnd >= 17'(FULL_TURN)) ? FULL_TURN - 1'b1 : rnd[15:0]);

    assign o_ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.least_angle = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min <= FULL_TURN;
            r_ovalid <= 1'b0;
        end else begin
            // The result state reloads the output register itself.
            if (r_ovalid && o_res.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    // Jobs that neither compute nor deliver are dropped here.
                    r_state <= i_job.eval ? S_EDGE : (i_job.emit ? S_OUT : S_IDLE);
                end
                S_EDGE: begin
                    r_ux <= EDGE_BITS'(dux >>> EDGE_SHIFT);
                    r_uy <= EDGE_BITS'(duy >>> EDGE_SHIFT);
                    r_wx <= EDGE_BITS'(dwx >>> EDGE_SHIFT);
                    r_wy <= EDGE_BITS'(dwy >>> EDGE_SHIFT);
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_p1 <= PROD_BITS'(r_ux * r_wx);
                    r_p2 <= PROD_BITS'(r_uy * r_wy);
                    r_p3 <= PROD_BITS'(r_ux * r_wy);
                    r_p4 <= PROD_BITS'(r_uy * r_wx);
                    r_state <= S_ROT;
                    r_i <= '1;
                end
                S_ROT: begin
                    if (r_i == '1) begin
                        // Prerotation by a quarter turn into the right half plane.
                        r_degen <= (dot == '0) && (ncr == '0);
                        r_i <= '0;
                        if (dot < 0 && ncr >= 0) begin
                            r_x <= ncr; r_y <= -dot; r_z <= 32'h40000000;
                        end else if (dot < 0) begin
                            r_x <= -ncr; r_y <= dot; r_z <= 32'hC0000000;
                        end else begin
                            r_x <= dot; r_y <= ncr; r_z <= '0;
                        end
                    end else begin
                        if (r_y >= 0) begin
                            r_x <= r_x + ys; r_y <= r_y - xs;
                            r_z <= r_z + atan_turn(5'(r_i));
                        end else begin
                            r_x <= r_x - ys; r_y <= r_y + xs;
                            r_z <= r_z - atan_turn(5'(r_i));
                        end
                        if (r_i == STEP_BITS'(CORDIC_STEPS - 1)) r_state <= S_SCALE;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_SCALE: begin
                    r_prod <= 48'(r_z) * 48'(FULL_TURN);
                    r_state <= S_MIN;
                end
                S_MIN: begin
                    if (ang < r_min) r_min <= ang;
                    r_state <= r_job.emit ? S_OUT : S_IDLE;
                end
                default: if (!r_ovalid || o_res.ready) begin
                    r_ovalid <= 1'b1;
                    r_out <= r_job.zero ? '0 : r_min;
                    r_min <= FULL_TURN;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== hw/rtl/polygon_min_corner_angle_unit.sv =====
// Top level of the minimum corner angle unit: front end, job queue, angle engine.
// Depends on pmca_pkg, pmca_if, pmca_front, pmca_queue and pmca_engine.
//
//   channel   dir  payload                              beat
//   i_vtx     in   vertex_x, vertex_y, last_vertex     one vertex
//   o_res     out  least_angle                          one polygon result
//
// Each corner passes through the angle engine in order: taking the job, edges,
// products, one prerotation and CORDIC_STEPS vectoring steps, scaling and
// minimum. A vertex that closes no corner and ends no polygon is dropped as the
// engine takes it. A closing vertex adds two wrap-around corners and a result
// state that loads the output register. Reset is synchronous and clears all
// control state. The job queue lets vertices be taken while the engine runs or
// the result waits; the output register holds a beat until it is taken.
module polygon_min_corner_angle_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pmca_vertex_if.sink  i_vtx,
    pmca_angle_if.source o_res
);
    import pmca_pkg::*;

    t_job f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;

    pmca_front u_front (.i_clk, .i_rst_n, .i_vtx,
        .o_job(f_job), .o_job_valid(f_valid), .i_job_ready(f_ready));
    pmca_queue u_queue (.i_clk, .i_rst_n, .i_job(f_job), .i_valid(f_valid),
        .o_ready(f_ready), .o_job(q_job), .o_valid(q_valid), .i_ready(q_ready));
    pmca_engine u_engine (.i_clk, .i_rst_n, .i_job(q_job), .i_valid(q_valid),
        .o_ready(q_ready), .o_res);
endmodule

// ===== test/polygon_min_corner_angle_unit_tb.sv =====
// Self-checking testbench for the minimum corner angle unit.
// Drives vertex beats through pmca_vertex_if, predicts each polygon's minimum
// angle with its own CORDIC model and checks every beat out of pmca_angle_if.
// Depends on pmca_pkg, pmca_if and polygon_min_corner_angle_unit.
module polygon_min_corner_angle_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pmca_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic i_clk;
    logic i_rst_n;

    pmca_vertex_if i_vtx ();
    pmca_angle_if  o_res ();

    polygon_min_corner_angle_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vtx  (i_vtx.sink),
        .o_res  (o_res.source)
    );

    // Clock with a 2 ns period.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Predictor state: stored vertices, running minimum and vertex count.
    longint poly_first_x [2];
    longint poly_first_y [2];
    longint poly_prev_x [2];
    longint poly_prev_y [2];
    int unsigned poly_min;
    int unsigned poly_count;

    logic [15:0] expected_angles[$];
    int   error_count;
    bit   idle_enable;
    int   stall_cycles;

    // Clear the predictor at the end of each polygon.
    task automatic clear_polygon();
        for (int i = 0; i < 2; i++) begin
            poly_first_x[i] = 0;
            poly_first_y[i] = 0;
            poly_prev_x[i]  = 0;
            poly_prev_y[i]  = 0;
        end
        poly_min   = 32'(FULL_TURN);
        poly_count = 0;
    endtask

    // Shift that rounds toward minus infinity (arithmetic shift of a longint).
    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    // Clockwise corner angle at b, in 1/128 degree.
    function automatic int unsigned corner_angle_units(longint ax, longint ay, longint bx,
                                                       longint by, longint cx, longint cy);
        longint ux, uy, wx, wy, dp, cp, x, y, z, t, xs, ys;
        logic [31:0] zt;
        longint unsigned r;
        ux = shift_floor(ax - bx, EDGE_SHIFT);
        uy = shift_floor(ay - by, EDGE_SHIFT);
        wx = shift_floor(cx - bx, EDGE_SHIFT);
        wy = shift_floor(cy - by, EDGE_SHIFT);
        dp = ux * wx + uy * wy;
        cp = ux * wy - uy * wx;
        if (dp == 0 && cp == 0) return 0;
        x = dp;
        y = -cp;
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 64'h40000000;
            end else begin
                t = x; x = -y; y = t; z = -64'sh40000000;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = shift_floor(x, i);
            ys = shift_floor(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + longint'(atan_turn(i[4:0]));
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(atan_turn(i[4:0]));
            end
        end
        zt = z[31:0];
        r  = (longint'(zt) * 46080 + 64'h80000000) >> 32;
        if (r >= FULL_TURN) r = FULL_TURN - 1;
        return int'(r);
    endfunction

    function automatic void keep_smaller(int unsigned a);
        if (a < poly_min) poly_min = a;
    endfunction

    // Advance the predictor by one accepted vertex.
    task automatic predict_vertex(logic signed [15:0] vx, logic signed [15:0] vy, logic lst);
        longint px, py;
        px = longint'(vx);
        py = longint'(vy);
        if (poly_count < MAX_VERTICES) poly_count++;
        if (poly_count == 1) begin
            poly_first_x[0] = px; poly_first_y[0] = py;
        end
        if (poly_count == 2) begin
            poly_first_x[1] = px; poly_first_y[1] = py;
        end
        if (poly_count >= 3)
            keep_smaller(corner_angle_units(poly_prev_x[0], poly_prev_y[0],
                                            poly_prev_x[1], poly_prev_y[1], px, py));
        poly_prev_x[0] = poly_prev_x[1]; poly_prev_y[0] = poly_prev_y[1];
        poly_prev_x[1] = px;             poly_prev_y[1] = py;
        if (lst) begin
            if (poly_count < 3) begin
                expected_angles.insert(expected_angles.size(), 16'd0);
            end else begin
                keep_smaller(corner_angle_units(poly_prev_x[0], poly_prev_y[0], px, py,
                                                poly_first_x[0], poly_first_y[0]));
                keep_smaller(corner_angle_units(px, py, poly_first_x[0], poly_first_y[0],
                                                poly_first_x[1], poly_first_y[1]));
                expected_angles.insert(expected_angles.size(), poly_min[15:0]);
            end
            clear_polygon();
        end
    endtask

    function automatic bit take_gap();
        return idle_enable && ($urandom_range(99) < 21);
    endfunction

    // Send one vertex beat and predict it once it is accepted. Valid stays high
    // into the next beat unless an idle cycle is taken.
    task automatic send_vertex(logic signed [15:0] vx, logic signed [15:0] vy, logic lst);
        while (take_gap()) begin
            i_vtx.valid <= 1'b0;
            @(negedge i_clk);
        end
        i_vtx.valid       <= 1'b1;
        i_vtx.vertex_x    <= vx;
        i_vtx.vertex_y    <= vy;
        i_vtx.last_vertex <= lst;
        do @(posedge i_clk); while (!i_vtx.ready);
        predict_vertex(vx, vy, lst);
        @(negedge i_clk);
    endtask

    task automatic send_polygon(int n, int spread);
        logic signed [15:0] cx, cy;
        cx = 16'($urandom);
        cy = 16'($urandom);
        for (int i = 0; i < n; i++)
            send_vertex(cx + $signed(16'($urandom_range(2 * spread) - spread)),
                        cy + $signed(16'($urandom_range(2 * spread) - spread)), i == n - 1);
    endtask

    // Result side: random stalls, then compare with the oldest expectation.
    always @(negedge i_clk) begin
        o_res.ready <= !(idle_enable && ($urandom_range(99) < 21));
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res.valid && o_res.ready) begin
            stall_cycles <= 0;
            if (expected_angles.size() == 0) begin
                $error("unexpected least_angle beat %0d", o_res.least_angle);
                error_count++;
            end else begin
                logic [15:0] want;
                want = expected_angles.pop_front();
                if (o_res.least_angle !== want) begin
                    $error("least_angle: expected %0d, actual %0d", want, o_res.least_angle);
                    error_count++;
                end
            end
        end else if (i_rst_n && i_vtx.valid && i_vtx.ready) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge i_clk) begin
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Extremes, degenerate corners, short polygons, a near-full-turn corner and a self-crossing polygon.
    task automatic test_directed();
        send_vertex(16'sd5, 16'sd5, 1'b1);                       // single vertex
        send_vertex(16'sd1, 16'sd2, 1'b0);
        send_vertex(-16'sd3, 16'sd4, 1'b1);                      // two vertices
        send_vertex(-16'sd32768, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, 16'sd32767, 1'b0);
        send_vertex(-16'sd32768, 16'sd32767, 1'b1);              // full-range square
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd10, 16'sd0, 1'b1);                      // repeated vertex
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd1000, 16'sd0, 1'b0);
        send_vertex(-16'sd1000, 16'sd1, 1'b1);                   // nearly full turn
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd100, 16'sd0, 1'b0);
        send_vertex(16'sd50, 16'sd100, 1'b0);
        send_vertex(16'sd50, -16'sd100, 1'b0);
        send_vertex(-16'sd1, -16'sd1, 1'b1);                     // self-crossing
    endtask

    // Mostly small random polygons, some with wide coordinates.
    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 1430) begin
            int n;
            n = ($urandom_range(19) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
            idle_enable = !(sent > 600 && sent < 800);
            send_polygon(n, ($urandom_range(3) == 0) ? 32767 : $urandom_range(1, 4000));
            sent += n;
        end
        idle_enable = 1'b1;
    endtask

    initial begin
        error_count       = 0;
        stall_cycles      = 0;
        idle_enable       = 1'b1;
        i_rst_n           = 1'b0;
        i_vtx.valid       = 1'b0;
        i_vtx.vertex_x    = '0;
        i_vtx.vertex_y    = '0;
        i_vtx.last_vertex = 1'b0;
        o_res.ready       = 1'b0;
        clear_polygon();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        i_vtx.valid <= 1'b0;
        while (expected_angles.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/pmca_pkg.sv
hw/rtl/pmca_if.sv
hw/rtl/pmca_front.sv
hw/rtl/pmca_queue.sv
hw/rtl/pmca_engine.sv
hw/rtl/polygon_min_corner_angle_unit.sv
test/polygon_min_corner_angle_unit_tb.sv
